// ----- hw/rtl/tftp_pkg.sv -----
// Shared types and codes for the TFTP read client control core.
// No dependencies; imported by every other file of the block.
package tftp_pkg;

    // Event kinds after classification by the front end
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_DATA  = 3'd1;
    localparam logic [2:0] CMD_ERR   = 3'd2;
    localparam logic [2:0] CMD_OTHER = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;
    localparam logic [2:0] CMD_FFAIL = 3'd5;
    localparam logic [2:0] CMD_NOP   = 3'd6;

    // Input request types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_PKT   = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_FLASH = 2'd3;

    // Received opcodes
    localparam logic [15:0] OP_DATA    = 16'd3;
    localparam logic [15:0] OP_ERR_PKT = 16'd5;

    localparam logic [15:0] ERR_NOT_FOUND = 16'd1;
    localparam logic [10:0] FULL_LEN      = 11'd516;
    localparam logic [10:0] HDR_LEN       = 11'd4;
    localparam logic [10:0] MAX_PAYLOAD   = 11'd512;

    // Result actions
    localparam logic [1:0] ACT_RRQ   = 2'd0;
    localparam logic [1:0] ACT_ACK   = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_FIN   = 2'd3;

    // Result codes
    localparam logic [2:0] RC_SUCCESS   = 3'd0;
    localparam logic [2:0] RC_FLASH_ERR = 3'd1;
    localparam logic [2:0] RC_NOT_FOUND = 3'd2;
    localparam logic [2:0] RC_SRV_DOWN  = 3'd3;
    localparam logic [2:0] RC_XFER_ERR  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] blk;
        logic [9:0]  wlen;
        logic        full;
        logic        ecode_one;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] ack_block;
        logic [9:0]  write_length;
        logic [2:0]  status_code;
        logic        busy_res;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  retry_limit;
    } cfg_t;

endpackage

// ----- hw/rtl/tftp_read_client_fsm_top.sv -----
// Top level of the TFTP read client control core: config registers, front end,
// command queue and back end. Depends on tftp_pkg, tftp_front, tftp_queue, tftp_back.
// A result passes through the command queue and the back-end output register to m_tvalid.
// Throughput: one event per cycle while the queue has room; an event yielding two results
// holds the back end until its first result is taken; the command queue absorbs the gap.
// Reset: asynchronous, clears transfer state and queue; timeout_ticks = 300, retry_limit = 3.
module tftp_read_client_fsm_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[15:0], block_number[31:16], err_code[47:32],
    // datagram_length[58:48], flash_failed[59], zero[63:60]
    input  logic [63:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ack_block[15:0], write_length[25:16], status_code[28:26], busy_res[29], zero[31:30]
    output logic [31:0] m_tdata,
    // action[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import tftp_pkg::*;

    cfg_t cfg_reg;
    logic q_full, push, pop, head_valid;
    cmd_t push_cmd, head_cmd;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= 16'd300;
            cfg_reg.retry_limit   <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                CFG_RETRY:   cfg_reg.retry_limit   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    tftp_front u_front (
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .req_type        (s_tuser),
        .opcode          (s_tdata[15:0]),
        .block_number    (s_tdata[31:16]),
        .err_code        (s_tdata[47:32]),
        .datagram_length (s_tdata[58:48]),
        .flash_failed    (s_tdata[59]),
        .q_full          (q_full),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    tftp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (q_full)
    );

    tftp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tuser = res.action;
    assign m_tlast = res.last;
    assign m_tdata = {2'b00, res.busy_res, res.status_code, res.write_length, res.ack_block};

endmodule

// ----- hw/rtl/tftp_front.sv -----
// Front end: accepts input transactions, classifies each event into a command.
// Depends on tftp_pkg; feeds tftp_queue.
module tftp_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         req_type,
    input  logic [15:0]        opcode,
    input  logic [15:0]        block_number,
    input  logic [15:0]        err_code,
    input  logic [10:0]        datagram_length,
    input  logic               flash_failed,
    input  logic               q_full,
    output logic               push,
    output tftp_pkg::cmd_t     push_cmd
);
    import tftp_pkg::*;

    logic [10:0] payload;

    assign s_tready = !q_full;

    always_comb
    begin
        payload = datagram_length - HDR_LEN;
        push_cmd           = '0;
        push_cmd.blk       = block_number;
        push_cmd.full      = (datagram_length == FULL_LEN);
        push_cmd.ecode_one = (err_code == ERR_NOT_FOUND);
        if (datagram_length < HDR_LEN)
            push_cmd.wlen = '0;
        else if (payload > MAX_PAYLOAD)
            push_cmd.wlen = MAX_PAYLOAD[9:0];
        else
            push_cmd.wlen = payload[9:0];

        unique case (req_type)
            REQ_START: push_cmd.kind = CMD_START;
            REQ_PKT:
            begin
                if (opcode == OP_DATA)
                    push_cmd.kind = CMD_DATA;
                else if (opcode == OP_ERR_PKT)
                    push_cmd.kind = CMD_ERR;
                else
                    push_cmd.kind = CMD_OTHER;
            end
            REQ_TICK:  push_cmd.kind = CMD_TICK;
            REQ_FLASH: push_cmd.kind = flash_failed ? CMD_FFAIL : CMD_NOP;
            default:   push_cmd.kind = CMD_NOP;
        endcase
    end

    // a good flash status never changes anything, so it is dropped here
    assign push = s_tvalid && !q_full && (push_cmd.kind != CMD_NOP);

endmodule

// ----- hw/rtl/tftp_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on tftp_pkg for the command type.
module tftp_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tftp_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output logic               head_valid,
    output tftp_pkg::cmd_t     head_cmd,
    output logic               full
);
    import tftp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- hw/rtl/tftp_back.sv -----
// Back end: transfer state machine, executes queued commands and emits results
// through an output register with one overflow slot. Depends on tftp_pkg.
module tftp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tftp_pkg::cfg_t     cfg,
    input  logic               cmd_valid,
    input  tftp_pkg::cmd_t     cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tftp_pkg::res_t     out_res
);
    import tftp_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_REQ    = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_LINGER = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] last_block_reg, last_block_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  retries_reg, retries_next;
    logic [7:0]  fec_reg, fec_next;

    logic        out_valid_reg;
    res_t        out_res_reg;
    logic        pend_valid_reg;
    res_t        pend_res_reg;

    res_t        r0, r1;
    logic [1:0]  n_res;
    logic        expired;
    logic        out_fire;

    function automatic res_t mk_res(logic [1:0] act, logic [15:0] blk,
                                    logic [9:0] wlen, logic [2:0] rc);
        res_t r;
        r.action       = act;
        r.ack_block    = blk;
        r.write_length = wlen;
        r.status_code  = rc;
        r.busy_res     = (act != ACT_FIN);
        r.last         = 1'b0;
        return r;
    endfunction

    assign out_fire  = out_valid_reg && out_ready;
    assign pop       = cmd_valid && !pend_valid_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign expired   = ({1'b0, tick_reg} + 17'd1) >= {1'b0, cfg.timeout_ticks};

    always_comb
    begin
        phase_next      = phase_reg;
        last_block_next = last_block_reg;
        tick_next       = tick_reg;
        retries_next    = retries_reg;
        fec_next        = fec_reg;
        r0              = '0;
        r1              = '0;
        n_res           = 2'd0;

        unique case (cmd.kind)
            CMD_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next      = PH_REQ;
                    last_block_next = '0;
                    fec_next        = '0;
                    tick_next       = '0;
                    retries_next    = cfg.retry_limit;
                    r0              = mk_res(ACT_RRQ, '0, '0, RC_SUCCESS);
                    n_res           = 2'd1;
                end
            end
            CMD_DATA:
            begin
                if (phase_reg == PH_REQ || phase_reg == PH_DATA)
                begin
                    // the first block is written whatever its number
                    if (phase_reg == PH_REQ || cmd.blk != last_block_reg)
                    begin
                        r0    = mk_res(ACT_WRITE, '0, cmd.wlen, RC_SUCCESS);
                        r1    = mk_res(ACT_ACK, cmd.blk, '0, RC_SUCCESS);
                        n_res = 2'd2;
                    end
                    else
                    begin
                        r0    = mk_res(ACT_ACK, cmd.blk, '0, RC_SUCCESS);
                        n_res = 2'd1;
                    end
                    last_block_next = cmd.blk;
                    tick_next       = '0;
                    if (cmd.full)
                    begin
                        phase_next   = PH_DATA;
                        retries_next = cfg.retry_limit;
                    end
                    else
                        phase_next = PH_LINGER;
                end
            end
            CMD_ERR, CMD_OTHER:
            begin
                if (phase_reg == PH_REQ || phase_reg == PH_DATA)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    n_res      = 2'd1;
                    if (phase_reg == PH_DATA)
                        r0 = mk_res(ACT_FIN, '0, '0, RC_XFER_ERR);
                    else if (cmd.kind == CMD_ERR && cmd.ecode_one)
                        r0 = mk_res(ACT_FIN, '0, '0, RC_NOT_FOUND);
                    else
                        r0 = mk_res(ACT_FIN, '0, '0, RC_SRV_DOWN);
                end
            end
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (!expired)
                        tick_next = tick_reg + 16'd1;
                    else if (phase_reg == PH_LINGER)
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        r0 = mk_res(ACT_FIN, '0, '0,
                                    (fec_reg != '0) ? RC_FLASH_ERR : RC_SUCCESS);
                        n_res = 2'd1;
                    end
                    else if (retries_reg <= 4'd1)
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        r0 = mk_res(ACT_FIN, '0, '0,
                                    (phase_reg == PH_REQ) ? RC_SRV_DOWN : RC_XFER_ERR);
                        n_res = 2'd1;
                    end
                    else
                    begin
                        retries_next = retries_reg - 4'd1;
                        tick_next    = '0;
                        n_res        = 2'd1;
                        if (phase_reg == PH_REQ)
                            r0 = mk_res(ACT_RRQ, '0, '0, RC_SUCCESS);
                        else
                            r0 = mk_res(ACT_ACK, last_block_reg, '0, RC_SUCCESS);
                    end
                end
            end
            CMD_FFAIL:
            begin
                if (phase_reg != PH_IDLE && fec_reg != 8'hFF)
                    fec_next = fec_reg + 8'd1;
            end
            default:
            begin
            end
        endcase

        if (n_res == 2'd1)
            r0.last = 1'b1;
        if (n_res == 2'd2)
            r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            last_block_reg <= '0;
            tick_reg       <= '0;
            retries_reg    <= '0;
            fec_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                last_block_reg <= last_block_next;
                tick_reg       <= tick_next;
                retries_reg    <= retries_next;
                fec_reg        <= fec_next;
            end
            if (pop && n_res != 2'd0)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= (n_res == 2'd2);
            end
            else if (out_fire)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop && n_res != 2'd0)
        begin
            out_res_reg  <= r0;
            pend_res_reg <= r1;
        end
        else if (out_fire)
            out_res_reg <= pend_res_reg;
    end

endmodule

// ----- hw/rtl/tftp_checker.sv -----
// Port-level checker for the TFTP read client core, bound to the top level.
// Depends on tftp_pkg and tftp_read_client_fsm_top.
module tftp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);
    import tftp_pkg::*;

    // a stalled result transaction stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // finished ends the event's results and clears busy
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ACT_FIN |-> m_tlast && !m_tdata[29])
        else $error("finished result not last or still busy");

    // a write order is always followed by its acknowledgement
    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ACT_WRITE |-> !m_tlast)
        else $error("write order without following ack");

    // every result other than finished reports busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ACT_FIN |-> m_tdata[29])
        else $error("busy flag low during transfer");

endmodule

bind tftp_read_client_fsm_top tftp_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- sim/tb.sv -----
// Self-checking bench for tftp_read_client_fsm_top: event stream in, action stream out.
// Depends on tftp_pkg and the block's RTL; a behavioural model of the client sets expectations.
module tb;
    import tftp_pkg::*;

    localparam logic [15:0] OP_ACK = 16'd4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        XF_IDLE,
        XF_AWAIT_FIRST,
        XF_AWAIT_BLOCK,
        XF_LINGER
    } xfer_phase_t;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] op;
        logic [15:0] blk;
        logic [15:0] ecode;
        logic [10:0] dlen;
        logic        ffail;
    } xfer_event_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // client model state and its copy of the registers
    xfer_phase_t xf_phase = XF_IDLE;
    logic [15:0] xf_last_blk = '0;
    logic [15:0] xf_ticks = '0;
    logic [3:0]  xf_retries = '0;
    logic [7:0]  xf_flash_errs = '0;
    logic [15:0] cfg_timeout_ticks = 16'd300;
    logic [3:0]  cfg_retry_limit = 4'd3;

    res_t results_due[$];

    int cycle_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int transfers_started = 0;
    int idle_pct = 0;
    bit rx_hold_req = 1'b0;

    tftp_read_client_fsm_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic res_t mk_result(input logic [1:0] act, input logic [15:0] blk,
                                       input logic [9:0] wlen, input logic [2:0] rc);
        res_t r;
        r.action       = act;
        r.ack_block    = blk;
        r.write_length = wlen;
        r.status_code  = rc;
        r.busy_res     = (act != ACT_FIN);
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic res_t end_transfer(input logic [2:0] rc);
        xf_phase = XF_IDLE;
        xf_ticks = '0;
        return mk_result(ACT_FIN, 16'd0, 10'd0, rc);
    endfunction

    function automatic xfer_event_t mk_event(input logic [1:0] req, input logic [15:0] op,
                                             input logic [15:0] blk, input logic [15:0] ecode,
                                             input logic [10:0] dlen, input logic ffail);
        xfer_event_t ev;
        ev.req   = req;
        ev.op    = op;
        ev.blk   = blk;
        ev.ecode = ecode;
        ev.dlen  = dlen;
        ev.ffail = ffail;
        return ev;
    endfunction

    // Advance the client model by one event and queue the actions it should produce
    task automatic client_predict(input xfer_event_t ev);
        res_t       outs[$];
        logic [9:0] wlen;
        logic       expired;
        case (ev.req)
            REQ_START:
            begin
                if (xf_phase == XF_IDLE)
                begin
                    xf_phase      = XF_AWAIT_FIRST;
                    xf_last_blk   = '0;
                    xf_flash_errs = '0;
                    xf_ticks      = '0;
                    xf_retries    = cfg_retry_limit;
                    transfers_started++;
                    outs.push_back(mk_result(ACT_RRQ, 16'd0, 10'd0, RC_SUCCESS));
                end
            end
            REQ_PKT:
            begin
                if ((xf_phase == XF_AWAIT_FIRST || xf_phase == XF_AWAIT_BLOCK) &&
                    ev.op == OP_DATA)
                begin
                    // the first block is always written; a repeat is only acknowledged
                    if (xf_phase == XF_AWAIT_FIRST || ev.blk != xf_last_blk)
                    begin
                        if (ev.dlen < HDR_LEN)
                            wlen = '0;
                        else if (ev.dlen - HDR_LEN > MAX_PAYLOAD)
                            wlen = MAX_PAYLOAD[9:0];
                        else
                            wlen = 10'(ev.dlen - HDR_LEN);
                        outs.push_back(mk_result(ACT_WRITE, 16'd0, wlen, RC_SUCCESS));
                    end
                    xf_last_blk = ev.blk;
                    xf_ticks    = '0;
                    if (ev.dlen == FULL_LEN)
                    begin
                        xf_phase   = XF_AWAIT_BLOCK;
                        xf_retries = cfg_retry_limit;
                    end
                    else
                        xf_phase = XF_LINGER;
                    outs.push_back(mk_result(ACT_ACK, ev.blk, 10'd0, RC_SUCCESS));
                end
                else if (xf_phase == XF_AWAIT_FIRST)
                begin
                    if (ev.op == OP_ERR_PKT && ev.ecode == ERR_NOT_FOUND)
                        outs.push_back(end_transfer(RC_NOT_FOUND));
                    else
                        outs.push_back(end_transfer(RC_SRV_DOWN));
                end
                else if (xf_phase == XF_AWAIT_BLOCK)
                    outs.push_back(end_transfer(RC_XFER_ERR));
            end
            REQ_TICK:
            begin
                if (xf_phase != XF_IDLE)
                begin
                    expired = ({1'b0, xf_ticks} + 17'd1) >= {1'b0, cfg_timeout_ticks};
                    if (!expired)
                        xf_ticks = xf_ticks + 16'd1;
                    else if (xf_phase == XF_LINGER)
                        outs.push_back(end_transfer(xf_flash_errs != 0 ? RC_FLASH_ERR
                                                                       : RC_SUCCESS));
                    else if (xf_retries <= 4'd1)
                        outs.push_back(end_transfer(xf_phase == XF_AWAIT_FIRST ? RC_SRV_DOWN
                                                                               : RC_XFER_ERR));
                    else
                    begin
                        xf_retries = xf_retries - 4'd1;
                        xf_ticks   = '0;
                        if (xf_phase == XF_AWAIT_FIRST)
                            outs.push_back(mk_result(ACT_RRQ, 16'd0, 10'd0, RC_SUCCESS));
                        else
                            outs.push_back(mk_result(ACT_ACK, xf_last_blk, 10'd0, RC_SUCCESS));
                    end
                end
            end
            default:
            begin
                if (xf_phase != XF_IDLE && ev.ffail && xf_flash_errs != 8'hFF)
                    xf_flash_errs = xf_flash_errs + 8'd1;
            end
        endcase
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            results_due.push_back(outs[i]);
    endtask

    task automatic send_event(input xfer_event_t ev);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ev.ffail, ev.dlen, ev.ecode, ev.blk, ev.op};
        s_tuser  <= ev.req;
        do
            @(posedge clk);
        while (!s_tready);
        client_predict(ev);
        items_sent++;
    endtask

    // sender pauses until every expected action is out and the pipe has emptied
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TIMEOUT)
            cfg_timeout_ticks = val;
        else
            cfg_retry_limit = val[3:0];
    endtask

    // receiver pacing: random stall bursts, plus one long hold on request
    initial
    begin : rx_pacing
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                hold_left = $urandom_range(1, 17);
            m_tready <= (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.action       = m_tuser;
            got.ack_block    = m_tdata[15:0];
            got.write_length = m_tdata[25:16];
            got.status_code  = m_tdata[28:26];
            got.busy_res     = m_tdata[29];
            got.last         = m_tlast;
            results_checked++;
            if (results_due.size() == 0)
                report_mismatch($sformatf("unexpected action %0d", got.action));
            else
            begin
                want = results_due.pop_front();
                if (got.action !== want.action)
                    report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
                if (got.ack_block !== want.ack_block)
                    report_mismatch($sformatf("ack_block %0d, want %0d",
                                              got.ack_block, want.ack_block));
                if (got.write_length !== want.write_length)
                    report_mismatch($sformatf("write_length %0d, want %0d",
                                              got.write_length, want.write_length));
                if (got.status_code !== want.status_code)
                    report_mismatch($sformatf("status_code %0d, want %0d",
                                              got.status_code, want.status_code));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %0b, want %0b",
                                              got.busy_res, want.busy_res));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            end
        end
    end

    // default registers: ignored events while idle, a start while busy, a bad packet
    task automatic test_reset_defaults();
        send_event(mk_event(REQ_FLASH, 16'd0, 16'd0, 16'd0, 11'd0, 1'b1));
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'd1, 16'd0, FULL_LEN, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, 16'hFFFF, 16'd1, 16'd0, FULL_LEN, 1'b0));
        drain_results();
    endtask

    task automatic test_directed_paths();
        write_reg(CFG_TIMEOUT, 16'd1);
        write_reg(CFG_RETRY, 16'd2);
        // error packet: file not found
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_ERR_PKT, 16'd0, ERR_NOT_FOUND, 11'd4, 1'b0));
        // ack as first reply
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_ACK, 16'd0, 16'd0, 11'd4, 1'b0));
        // request retried, then server down
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        // duplicate block, ack resend, tiny last block, linger with a flash failure
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'hFFFF, 16'd0, FULL_LEN, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'hFFFF, 16'd0, FULL_LEN, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'd0, 16'd0, 11'd3, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'd1, 16'd0, FULL_LEN, 1'b0));
        send_event(mk_event(REQ_FLASH, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_FLASH, 16'd0, 16'd0, 16'd0, 11'd0, 1'b1));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        // oversized single block, clean finish
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'd1, 16'd0, 11'd2047, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        // short block repeating the previous number
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'd7, 16'd0, FULL_LEN, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'd7, 16'd0, 11'd100, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        // ack retries used up while waiting for the next block
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_DATA, 16'd2, 16'd0, FULL_LEN, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        drain_results();
    endtask

    task automatic test_setting_extremes();
        // zero timeout expires at once, zero retry limit allows a single attempt
        write_reg(CFG_TIMEOUT, 16'd0);
        write_reg(CFG_RETRY, 16'd0);
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        drain_results();
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_RETRY, 16'd15);
        send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_TICK, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
        send_event(mk_event(REQ_PKT, OP_ERR_PKT, 16'd0, 16'h8000, 11'd4, 1'b0));
        drain_results();
    endtask

    // receiver holds off while the sender keeps going, so the input side must stall
    task automatic test_backpressure();
        write_reg(CFG_TIMEOUT, 16'd4);
        write_reg(CFG_RETRY, 16'd3);
        idle_pct = 0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            send_event(mk_event(REQ_START, 16'd0, 16'd0, 16'd0, 11'd0, 1'b0));
            send_event(mk_event(REQ_PKT, OP_ACK, 16'd0, 16'd0, 11'd4, 1'b0));
        end
        drain_results();
    endtask

    // mostly well-formed transfers steered by the model phase, with some noise
    function automatic xfer_event_t pick_event();
        xfer_event_t ev;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        ev = mk_event(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      11'($urandom), 1'($urandom));
        if (roll < 8)
            return ev;
        if ($urandom_range(0, 99) < 80)
            ev.dlen = FULL_LEN;
        roll = $urandom_range(0, 99);
        case (xf_phase)
            XF_IDLE:
                ev.req = REQ_START;
            XF_AWAIT_FIRST:
            begin
                if (roll < 55)
                begin
                    ev.req = REQ_PKT;
                    ev.op  = OP_DATA;
                end
                else if (roll < 65)
                begin
                    ev.req = REQ_PKT;
                    ev.op  = OP_ERR_PKT;
                    if ($urandom_range(0, 1) == 0)
                        ev.ecode = ERR_NOT_FOUND;
                end
                else if (roll < 70)
                    ev.req = REQ_PKT;
                else if (roll < 88)
                    ev.req = REQ_TICK;
                else
                    ev.req = REQ_FLASH;
            end
            XF_AWAIT_BLOCK:
            begin
                if (roll < 60)
                begin
                    ev.req = REQ_PKT;
                    ev.op  = OP_DATA;
                    roll = $urandom_range(0, 99);
                    if (roll < 80)
                        ev.blk = xf_last_blk + 16'd1;
                    else if (roll < 95)
                        ev.blk = xf_last_blk;
                end
                else if (roll < 80)
                    ev.req = REQ_TICK;
                else if (roll < 88)
                    ev.req = REQ_FLASH;
                else if (roll < 94)
                    ev.req = REQ_PKT;
                else
                    ev.req = REQ_START;
            end
            default:
            begin
                if (roll < 65)
                    ev.req = REQ_TICK;
                else if (roll < 80)
                begin
                    ev.req = REQ_PKT;
                    ev.op  = OP_DATA;
                end
                else
                    ev.req = REQ_FLASH;
            end
        endcase
        return ev;
    endfunction

    task automatic test_random_transfers();
        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 10)));
            write_reg(CFG_RETRY, 16'($urandom_range(0, 15)));
            // last phase runs with no idling on either side
            idle_pct = (p == 1 || p == 4) ? 0 : 10 + 12 * p;
            for (int k = 0; k < 80; k++)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_event(pick_event());
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        idle_pct = 20;
        test_directed_paths();
        test_setting_extremes();
        test_backpressure();
        test_random_transfers();
        drain_results();

        $display("covered %0d input transactions over %0d transfers, %0d actions checked",
                 items_sent, transfers_started, results_checked);
        $display("register settings swept from zero to full scale, with long output hold-off");
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tftp_pkg.sv
hw/rtl/tftp_front.sv
hw/rtl/tftp_queue.sv
hw/rtl/tftp_back.sv
hw/rtl/tftp_read_client_fsm_top.sv
hw/rtl/tftp_checker.sv
sim/tb.sv
